// ===== rtl/clr_pkg.sv =====
// shared types and constants of the command line receiver
package clr_pkg;

	localparam int LINE_DEPTH_DEF = 32;
	localparam int MAX_ARGS_DEF = 4;

	localparam int BYTE_W = 8;
	localparam int TOKEN_W = 3;
	localparam int CFG_INDEX_W = 1;

	localparam logic [BYTE_W-1:0] CH_QUESTION = 8'h3F;
	localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [BYTE_W-1:0] CH_RETURN = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_PROMPT = 8'h3E;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

	localparam logic [CFG_INDEX_W-1:0] REG_ISP_ENTRY_ENABLED = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_HANDLER_PRESENT = 1'd1;

	localparam logic CMD_RX_BYTE = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef struct packed {
		logic              command;
		logic [BYTE_W-1:0] rx_byte;
	} in_t;

	typedef struct packed {
		logic               tx_valid;
		logic [BYTE_W-1:0]  tx_byte;
		logic               line_valid;
		logic [BYTE_W-1:0]  line_char;
		logic               separator;
		logic [TOKEN_W-1:0] token_index;
		logic               isp_request;
		logic               overflow_cleared;
		logic               last;
	} out_t;

	// controller to datapath
	typedef struct packed {
		logic take_item;
		logic rd_en;
		logic emit_echo;
		logic emit_newline;
		logic emit_char;
		logic emit_prompt;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_cmd;
		logic is_return;
		logic handler;
		logic len_zero;
		logic char_end;
		logic char_final;
		logic slot_free;
	} sts_t;

endpackage

// ===== rtl/clr_ram.sv =====
// generic single write port ram with registered read
module clr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/clr_datapath.sv =====
// line store, position and token counters, config registers and result register
module clr_datapath #(
	parameter int LINE_DEPTH = clr_pkg::LINE_DEPTH_DEF,
	parameter int MAX_ARGS = clr_pkg::MAX_ARGS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  clr_pkg::in_t                      in_data,
	input  logic                              cfg_valid,
	input  logic [clr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic                              cfg_data,
	input  clr_pkg::cmd_t                     cmd,
	output clr_pkg::sts_t                     sts,
	output logic                              out_valid,
	input  logic                              out_ready,
	output clr_pkg::out_t                     out_data
);
	import clr_pkg::*;

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int TW = $clog2(MAX_ARGS + 1);

	logic              isp_en_q;
	logic              handler_q;
	logic [AW-1:0]     pos_q;
	logic [AW-1:0]     len_q;
	logic [AW-1:0]     idx_q;
	logic [TW-1:0]     tok_q;
	logic [BYTE_W-1:0] byte_q;
	logic              ovf_q;
	logic              out_valid_q;
	out_t              out_q;

	logic              ovf_now;
	logic [AW-1:0]     eff_pos;
	logic              store_we;
	logic [BYTE_W-1:0] rd_char;
	logic              is_space;
	logic [TW-1:0]     tok_nx;
	logic              slot_free;
	out_t              res;

	assign ovf_now = (pos_q >= AW'(LINE_DEPTH - 1));
	assign eff_pos = ovf_now ? '0 : pos_q;
	assign store_we = cmd.take_item && (in_data.command == CMD_RX_BYTE)
		&& (in_data.rx_byte != CH_BACKSPACE) && (in_data.rx_byte != CH_RETURN);

	clr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(LINE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(eff_pos),
		.wdata(in_data.rx_byte),
		.re   (cmd.rd_en),
		.raddr(idx_q),
		.rdata(rd_char)
	);

	assign is_space = (rd_char == CH_SPACE);
	assign tok_nx = is_space ? tok_q + TW'(1) : tok_q;
	assign slot_free = !out_valid_q || out_ready;

	assign sts.clear_cmd = (in_data.command == CMD_CLEAR);
	assign sts.is_return = (byte_q == CH_RETURN);
	assign sts.handler = handler_q;
	assign sts.len_zero = (len_q == '0);
	assign sts.char_end = (rd_char == '0) || (is_space && (tok_q >= TW'(MAX_ARGS)));
	assign sts.char_final = (idx_q == len_q - AW'(1));
	assign sts.slot_free = slot_free;

	always_comb begin
		res = '0;
		if (cmd.emit_echo) begin
			res.tx_valid = 1'b1;
			res.tx_byte = byte_q;
			res.isp_request = (byte_q == CH_QUESTION) && isp_en_q;
			res.overflow_cleared = ovf_q;
			res.last = (byte_q != CH_RETURN);
		end else if (cmd.emit_newline) begin
			res.tx_valid = 1'b1;
			res.tx_byte = CH_NEWLINE;
			res.last = !handler_q;
		end else if (cmd.emit_char) begin
			res.line_valid = 1'b1;
			res.line_char = is_space ? '0 : rd_char;
			res.separator = is_space;
			res.token_index = TOKEN_W'(tok_nx);
		end else if (cmd.emit_prompt) begin
			res.tx_valid = 1'b1;
			res.tx_byte = CH_PROMPT;
			res.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isp_en_q <= 1'b1;
			handler_q <= 1'b0;
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_ISP_ENTRY_ENABLED) begin
					isp_en_q <= cfg_data;
				end else if (cfg_index == REG_COMMAND_HANDLER_PRESENT) begin
					handler_q <= cfg_data;
				end
			end
			if (cmd.take_item) begin
				if (in_data.command == CMD_CLEAR) begin
					pos_q <= '0;
				end else if (in_data.rx_byte == CH_BACKSPACE) begin
					pos_q <= (eff_pos == '0) ? '0 : eff_pos - AW'(1);
				end else if (in_data.rx_byte == CH_RETURN) begin
					pos_q <= '0;
				end else begin
					pos_q <= eff_pos + AW'(1);
				end
			end
			if (cmd.emit_echo || cmd.emit_newline || cmd.emit_char || cmd.emit_prompt) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			byte_q <= in_data.rx_byte;
			ovf_q <= ovf_now;
			len_q <= eff_pos;
			idx_q <= '0;
			tok_q <= '0;
		end else if (cmd.emit_char) begin
			idx_q <= idx_q + AW'(1);
			tok_q <= tok_nx;
		end
		if (cmd.emit_echo || cmd.emit_newline || cmd.emit_char || cmd.emit_prompt) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// ===== rtl/clr_controller.sv =====
// sequencing state machine of the command line receiver
module clr_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  clr_pkg::sts_t sts,
	output clr_pkg::cmd_t cmd
);
	import clr_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_ECHO    = 6'b000010,
		ST_NEWLINE = 6'b000100,
		ST_READ    = 6'b001000,
		ST_WALK    = 6'b010000,
		ST_PROMPT  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_item = 1'b1;
					if (!sts.clear_cmd) begin
						state_d = ST_ECHO;
					end
				end
			end
			ST_ECHO: begin
				if (sts.slot_free) begin
					cmd.emit_echo = 1'b1;
					state_d = sts.is_return ? ST_NEWLINE : ST_IDLE;
				end
			end
			ST_NEWLINE: begin
				if (sts.slot_free) begin
					cmd.emit_newline = 1'b1;
					if (!sts.handler) begin
						state_d = ST_IDLE;
					end else if (sts.len_zero) begin
						state_d = ST_PROMPT;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d = ST_WALK;
			end
			ST_WALK: begin
				if (sts.char_end) begin
					state_d = ST_PROMPT;
				end else if (sts.slot_free) begin
					cmd.emit_char = 1'b1;
					state_d = sts.char_final ? ST_PROMPT : ST_READ;
				end
			end
			ST_PROMPT: begin
				if (sts.slot_free) begin
					cmd.emit_prompt = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/command_line_receiver.sv =====
// Serial console line editor: echoes every received byte, edits a line store of
// LINE_DEPTH bytes and, on carriage return, sends newline and, with a handler,
// the tokenized line and a '>' prompt. One input transfer is taken at a time. A
// clear command is taken without leaving the idle state; an ordinary byte is
// taken and its echo then loaded into the output register once the output slot
// is free. With a handler, the line walk issues one line store read per stored
// character and emits the character from its registered data. The store is
// cleared by resetting its fill count, so no clearing pass follows reset. Output
// back pressure stalls the sequence. Configuration writes are always taken.
module command_line_receiver #(
	parameter int LINE_DEPTH = clr_pkg::LINE_DEPTH_DEF,
	parameter int MAX_ARGS = clr_pkg::MAX_ARGS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  clr_pkg::in_t                      in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output clr_pkg::out_t                     out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [clr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic                              cfg_data
);
	import clr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	clr_controller u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	clr_datapath #(
		.LINE_DEPTH(LINE_DEPTH),
		.MAX_ARGS  (MAX_ARGS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of the command line receiver with a class scoreboard
module testbench;
	import clr_pkg::*;

	localparam int LINE_DEPTH = LINE_DEPTH_DEF;
	localparam int MAX_ARGS = MAX_ARGS_DEF;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS = 36;

	class console_scoreboard;
		logic [BYTE_W-1:0] line_buf [LINE_DEPTH];
		int unsigned write_pos;
		logic isp_enabled;
		logic handler_present;
		out_t pending_results [$];
		int errors;

		function new();
			isp_enabled = 1'b1;
			handler_present = 1'b0;
			errors = 0;
			clear_line();
		endfunction

		function void clear_line();
			foreach (line_buf[i]) begin
				line_buf[i] = '0;
			end
			write_pos = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] index, logic value);
			case (index)
				REG_ISP_ENTRY_ENABLED: isp_enabled = value;
				REG_COMMAND_HANDLER_PRESENT: handler_present = value;
				default: ;
			endcase
		endfunction

		function out_t tx_result(logic [BYTE_W-1:0] b);
			out_t r;
			r = '0;
			r.tx_valid = 1'b1;
			r.tx_byte = b;
			return r;
		endfunction

		function out_t line_result(logic [BYTE_W-1:0] c, logic sep, int unsigned tok);
			out_t r;
			r = '0;
			r.line_valid = 1'b1;
			r.line_char = c;
			r.separator = sep;
			r.token_index = TOKEN_W'(tok);
			return r;
		endfunction

		function void note_transfer(in_t item);
			out_t run [$];
			out_t r;
			int unsigned tok;
			logic [BYTE_W-1:0] c;
			logic ovf;
			if (item.command == CMD_CLEAR) begin
				clear_line();
				return;
			end
			ovf = 1'b0;
			if (write_pos >= LINE_DEPTH - 1) begin
				clear_line();
				ovf = 1'b1;
			end
			r = tx_result(item.rx_byte);
			r.isp_request = (item.rx_byte == CH_QUESTION) && isp_enabled;
			r.overflow_cleared = ovf;
			run.push_back(r);
			if (item.rx_byte == CH_BACKSPACE) begin
				if (write_pos > 0)
					write_pos--;
				line_buf[write_pos] = '0;
			end else if (item.rx_byte == CH_RETURN) begin
				run.push_back(tx_result(CH_NEWLINE));
				if (handler_present) begin
					tok = 0;
					for (int i = 0; i < LINE_DEPTH - 1; i++) begin
						c = line_buf[i];
						if (c == 8'h00)
							break;
						if (c == CH_SPACE) begin
							if (tok >= MAX_ARGS)
								break;
							tok++;
							run.push_back(line_result(8'h00, 1'b1, tok));
						end else begin
							run.push_back(line_result(c, 1'b0, tok));
						end
					end
					run.push_back(tx_result(CH_PROMPT));
				end
				clear_line();
			end else begin
				line_buf[write_pos] = item.rx_byte;
				write_pos++;
			end
			foreach (run[i]) begin
				r = run[i];
				r.last = (i == run.size() - 1);
				pending_results.push_back(r);
			end
		endfunction

		function string to_text(out_t r);
			return $sformatf("tx %0b:%h line %0b:%h sep %0b tok %0d isp %0b ovf %0b last %0b",
				r.tx_valid, r.tx_byte, r.line_valid, r.line_char, r.separator,
				r.token_index, r.isp_request, r.overflow_cleared, r.last);
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 10)
				$display("%0t: %s", $realtime, msg);
		endfunction

		function void check_result(out_t got);
			out_t want;
			logic differs;
			if (pending_results.size() == 0) begin
				report({"result with nothing expected: ", to_text(got)});
				return;
			end
			want = pending_results.pop_front();
			differs = got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
				got.line_valid !== want.line_valid || got.line_char !== want.line_char ||
				got.separator !== want.separator || got.token_index !== want.token_index ||
				got.isp_request !== want.isp_request ||
				got.overflow_cleared !== want.overflow_cleared || got.last !== want.last;
			if (differs)
				report({"expected ", to_text(want), " got ", to_text(got)});
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic cfg_data = 1'b0;

	console_scoreboard sb = new();
	int burst_left = 0;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;
	int stall_mode = 0;

	command_line_receiver i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stall pattern in one of four randomly picked modes
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count % 97 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (cycle_count % 5 != 0);
			default: out_ready <= (cycle_count % 4 == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(out_data);
			if (in_valid && in_ready)
				sb.note_transfer(in_data);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	task automatic send_item(input in_t item);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 5);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic send_rx(input logic [BYTE_W-1:0] b);
		send_item(in_t'{command: CMD_RX_BYTE, rx_byte: b});
	endtask

	task automatic send_clear();
		send_item(in_t'{command: CMD_CLEAR, rx_byte: BYTE_W'($urandom_range(0, 255))});
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_rx(s[i]);
		end
	endtask

	// hold off the sender until every expected result has been seen
	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic isp, input logic handler);
		cfg_valid <= 1'b1;
		cfg_index <= REG_ISP_ENTRY_ENABLED;
		cfg_data <= isp;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_COMMAND_HANDLER_PRESENT;
		cfg_data <= handler;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_line();
		int len;
		int pick;
		logic [BYTE_W-1:0] b;
		len = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 12);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				b = 8'h61 + BYTE_W'($urandom_range(0, 25));
			else if (pick < 55)
				b = 8'h30 + BYTE_W'($urandom_range(0, 9));
			else if (pick < 75)
				b = CH_SPACE;
			else if (pick < 80)
				b = CH_BACKSPACE;
			else if (pick < 83)
				b = CH_QUESTION;
			else if (pick < 86)
				b = 8'h00;
			else
				b = BYTE_W'($urandom_range(0, 255));
			send_rx(b);
		end
		pick = $urandom_range(0, 99);
		if (pick < 75)
			send_rx(CH_RETURN);
		else if (pick < 85)
			send_clear();
	endtask

	task automatic run_phase(input logic isp, input logic handler);
		int unsigned start;
		drain_results();
		configure(isp, handler);
		start = items_sent;
		while (items_sent - start < PHASE_ITEMS) begin
			if ($urandom_range(0, 9) < 8)
				send_line();
			else
				send_item(in_t'{command: ($urandom_range(0, 7) == 0),
					rx_byte: BYTE_W'($urandom_range(0, 255))});
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: question mark requests isp, no handler
		send_rx(CH_QUESTION);
		send_rx(8'h61);
		send_rx(8'hFF);
		send_rx(8'h00);
		send_rx(CH_RETURN);
		send_rx(CH_BACKSPACE);
		send_clear();
		drain_results();
		configure(1'b0, 1'b1);
		send_rx(CH_QUESTION);
		send_rx(CH_RETURN);
		send_text("a b c d e f");
		send_rx(CH_RETURN);
		send_rx(CH_RETURN);
		send_rx(8'h71);
		send_rx(CH_BACKSPACE);
		send_rx(CH_BACKSPACE);
		send_rx(CH_RETURN);

		run_phase(1'b1, 1'b1);
		run_phase(1'b0, 1'b0);
		run_phase(1'b1, 1'b0);
		run_phase(1'b0, 1'b1);
		drain_results();

		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

endmodule
